// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checks in the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks off while in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checks off while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bcharge_pkg.sv =====
// shared widths, types, register codes and charge curve for the battery adc converter
package bcharge_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int REF_W      = 13;
  localparam int KOHM_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // scaling datapath widths
  localparam int PA_W  = SAMPLE_W + REF_W;   // code * reference
  localparam int SUM_W = KOHM_W + 1;         // high + low divider
  localparam int NUM_W = PA_W + SUM_W;       // full numerator
  localparam int DEN_W = SAMPLE_W + KOHM_W;  // full scale * low divider
  localparam int DVD_W = NUM_W + 1;          // numerator plus rounding term
  localparam int REM_W = DEN_W + MV_W;       // remainder, holds den << MV_W

  // register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_SCALE,
    REG_REFERENCE_MV,
    REG_DIVIDER_HIGH,
    REG_DIVIDER_LOW
  } cfg_reg_t;

  // register reset values
  localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST   = SAMPLE_W'(4095);
  localparam logic [REF_W-1:0]    REFERENCE_MV_RST = REF_W'(3300);
  localparam logic [KOHM_W-1:0]   DIVIDER_HIGH_RST = KOHM_W'(100);
  localparam logic [KOHM_W-1:0]   DIVIDER_LOW_RST  = KOHM_W'(22);

  typedef struct packed {
    logic [SAMPLE_W-1:0] full_scale;
    logic [REF_W-1:0]    reference_mv;
    logic [KOHM_W-1:0]   divider_high;
    logic [KOHM_W-1:0]   divider_low;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
  } result_t;

  // charge curve breakpoints
  localparam int unsigned CURVE_MV0 = 10500;
  localparam int unsigned CURVE_MV1 = 11100;
  localparam int unsigned CURVE_MV2 = 11550;
  localparam int unsigned CURVE_MV3 = 12000;
  localparam int unsigned CURVE_MV4 = 12600;
  localparam int unsigned CURVE_PCT0 = 0;
  localparam int unsigned CURVE_PCT1 = 15;
  localparam int unsigned CURVE_PCT2 = 50;
  localparam int unsigned CURVE_PCT3 = 80;
  localparam int unsigned CURVE_PCT4 = 100;

  localparam int SEG_N = 4;
  localparam int SEG_W = 2;
  localparam int OFF_W = 10;       // offset within a segment, span at most 600
  localparam int X_W   = 15;       // off * rise + span / 2
  localparam int Q_W   = 6;        // per-segment quotient, at most the rise
  localparam int RCP_W = 16;
  localparam int RECIP_SH = 24;
  localparam int PRD_W = X_W + RCP_W;

  localparam logic [MV_W-1:0]  MV_FLOOR   = MV_W'(CURVE_MV0);
  localparam logic [MV_W-1:0]  MV_CEIL    = MV_W'(CURVE_MV4);
  localparam logic [PCT_W-1:0] PCT_EMPTY  = PCT_W'(CURVE_PCT0);
  localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(CURVE_PCT4);

  localparam logic [MV_W-1:0] SEG_LO_MV [SEG_N] = '{
    MV_W'(CURVE_MV0), MV_W'(CURVE_MV1), MV_W'(CURVE_MV2), MV_W'(CURVE_MV3)
  };
  localparam logic [MV_W-1:0] SEG_HI_MV [SEG_N] = '{
    MV_W'(CURVE_MV1), MV_W'(CURVE_MV2), MV_W'(CURVE_MV3), MV_W'(CURVE_MV4)
  };
  localparam logic [PCT_W-1:0] SEG_LO_PCT [SEG_N] = '{
    PCT_W'(CURVE_PCT0), PCT_W'(CURVE_PCT1), PCT_W'(CURVE_PCT2), PCT_W'(CURVE_PCT3)
  };
  localparam logic [PCT_W-1:0] SEG_RISE [SEG_N] = '{
    PCT_W'(CURVE_PCT1 - CURVE_PCT0), PCT_W'(CURVE_PCT2 - CURVE_PCT1),
    PCT_W'(CURVE_PCT3 - CURVE_PCT2), PCT_W'(CURVE_PCT4 - CURVE_PCT3)
  };
  localparam logic [OFF_W-1:0] SEG_SPAN [SEG_N] = '{
    OFF_W'(CURVE_MV1 - CURVE_MV0), OFF_W'(CURVE_MV2 - CURVE_MV1),
    OFF_W'(CURVE_MV3 - CURVE_MV2), OFF_W'(CURVE_MV4 - CURVE_MV3)
  };
  // floor(2^RECIP_SH / span), quotient estimate is exact or one low
  localparam logic [RCP_W-1:0] SEG_RECIP [SEG_N] = '{
    RCP_W'((2 ** RECIP_SH) / (CURVE_MV1 - CURVE_MV0)),
    RCP_W'((2 ** RECIP_SH) / (CURVE_MV2 - CURVE_MV1)),
    RCP_W'((2 ** RECIP_SH) / (CURVE_MV3 - CURVE_MV2)),
    RCP_W'((2 ** RECIP_SH) / (CURVE_MV4 - CURVE_MV3))
  };

endpackage

// ===== hw/rtl/adc_sample_if.sv =====
// input channel carrying one raw adc sample per beat
interface adc_sample_if;
  import bcharge_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// ===== hw/rtl/charge_result_if.sv =====
// output channel carrying millivolts and charge percent per beat
interface charge_result_if;
  import bcharge_pkg::*;

  logic             valid;
  logic             ready;
  logic [MV_W-1:0]  battery_millivolts;
  logic [PCT_W-1:0] charge_percent;

  modport source (output valid, output battery_millivolts, output charge_percent,
                  input ready);
  modport sink   (input valid, input battery_millivolts, input charge_percent,
                  output ready);
endinterface

// ===== hw/rtl/cfg_write_if.sv =====
// configuration write channel: register index and data per beat
interface cfg_write_if;
  import bcharge_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bcharge_scale.sv =====
// adc code to millivolts: clamp, multiply, rounded restoring division, saturation
module bcharge_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [bcharge_pkg::SAMPLE_W-1:0] code,
  input  bcharge_pkg::cfg_t             cfg,
  output logic                          out_v,
  output logic [bcharge_pkg::MV_W-1:0]  mv
);
  import bcharge_pkg::*;

  // front stages: clamp/multiply, multiply, round, overflow check
  localparam int NS = 4 + MV_W;

  logic [NS-1:0] v;

  logic [SAMPLE_W-1:0] code_c;
  logic [PA_W-1:0]     prod_a;
  logic [SUM_W-1:0]    rsum;
  logic [DEN_W-1:0]    den0;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den1;
  logic [DVD_W-1:0]    dvd;
  logic [DEN_W-1:0]    den2;

  // division stage registers, index 0 is the overflow check stage
  logic [REM_W-1:0] rem_q [0:MV_W-1];
  logic [DEN_W-1:0] dd    [0:MV_W-1];
  logic [MV_W-1:0]  quo   [0:MV_W];
  logic             ovf_q [0:MV_W];

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_v};
    end
  end

  // clamp to full scale
  assign code_c = (code > cfg.full_scale) ? cfg.full_scale : code;

  // stage 0: code * reference, denominator, resistor sum
  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= PA_W'(code_c) * PA_W'(cfg.reference_mv);
      den0   <= DEN_W'(cfg.full_scale) * DEN_W'(cfg.divider_low);
      rsum   <= SUM_W'(cfg.divider_high) + SUM_W'(cfg.divider_low);
    end
  end

  // stage 1: full numerator
  always_ff @(posedge clk) begin
    if (en) begin
      num  <= NUM_W'(prod_a) * NUM_W'(rsum);
      den1 <= den0;
    end
  end

  // stage 2: add half the divisor for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      dvd  <= DVD_W'(num) + DVD_W'(den1 >> 1);
      den2 <= den1;
    end
  end

  // stage 3: quotient past 16 bits saturates; zero divisor lands here too
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0] <= REM_W'(dvd) >= {den2, {MV_W{1'b0}}};
      rem_q[0] <= REM_W'(dvd);
      dd[0]    <= den2;
      quo[0]   <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= MV_W; k++) begin : g_div
    localparam int B = MV_W - k;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic [MV_W-1:0]  quo_next;

    always_comb begin
      trial       = REM_W'(dd[k-1]) << B;
      ge          = rem_q[k-1] >= trial;
      quo_next    = quo[k-1];
      quo_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k]   <= quo_next;
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < MV_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? (rem_q[k-1] - trial) : rem_q[k-1];
          dd[k]    <= dd[k-1];
        end
      end
    end
  end

  assign out_v = v[NS-1];
  assign mv    = ovf_q[MV_W] ? {MV_W{1'b1}} : quo[MV_W];

endmodule

// ===== hw/rtl/bcharge_interp.sv =====
// millivolts to charge percent by rounded interpolation over the battery curve
module bcharge_interp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [bcharge_pkg::MV_W-1:0]  mv,
  output logic                          out_v,
  output logic [bcharge_pkg::MV_W-1:0]  mv_out,
  output logic [bcharge_pkg::PCT_W-1:0] pct
);
  import bcharge_pkg::*;

  localparam int NS = 5;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [SEG_W-1:0] seg;
    logic             lo;
    logic             hi;
  } carry_t;

  logic [NS-1:0] v;

  logic [SEG_W-1:0] seg_sel;
  carry_t           c0, c1, c2, c3;
  logic [OFF_W-1:0] off0;
  logic [X_W-1:0]   x1, x2, x3;
  logic [Q_W-1:0]   q2, q3;
  logic [X_W-1:0]   p3;
  logic [X_W-1:0]   rem4;
  logic             fix4;

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_v};
    end
  end

  // segment search: first breakpoint at or above the input
  always_comb begin
    priority if (mv <= SEG_HI_MV[0]) begin
      seg_sel = SEG_W'(0);
    end else if (mv <= SEG_HI_MV[1]) begin
      seg_sel = SEG_W'(1);
    end else if (mv <= SEG_HI_MV[2]) begin
      seg_sel = SEG_W'(2);
    end else begin
      seg_sel = SEG_W'(3);
    end
  end

  // stage 0: segment, offset into it, clamp flags
  always_ff @(posedge clk) begin
    if (en) begin
      c0.mv  <= mv;
      c0.seg <= seg_sel;
      c0.lo  <= mv <= MV_FLOOR;
      c0.hi  <= mv >= MV_CEIL;
      off0   <= OFF_W'(mv - SEG_LO_MV[seg_sel]);
    end
  end

  // stage 1: off * rise plus half span
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= c0;
      x1 <= X_W'(off0) * X_W'(SEG_RISE[c0.seg]) + X_W'(SEG_SPAN[c0.seg] >> 1);
    end
  end

  // stage 2: quotient estimate by reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c1;
      x2 <= x1;
      q2 <= Q_W'((PRD_W'(x1) * PRD_W'(SEG_RECIP[c1.seg])) >> RECIP_SH);
    end
  end

  // stage 3: back-multiply the estimate
  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c2;
      x3 <= x2;
      q3 <= q2;
      p3 <= X_W'(q2) * X_W'(SEG_SPAN[c2.seg]);
    end
  end

  // estimate may be one low
  assign rem4 = x3 - p3;
  assign fix4 = rem4 >= X_W'(SEG_SPAN[c3.seg]);

  // stage 4: corrected percent with clamps at both ends
  always_ff @(posedge clk) begin
    if (en) begin
      mv_out <= c3.mv;
      if (c3.lo) begin
        pct <= PCT_EMPTY;
      end else if (c3.hi) begin
        pct <= PCT_FULL;
      end else begin
        pct <= SEG_LO_PCT[c3.seg] + PCT_W'(q3) + PCT_W'(fix4);
      end
    end
  end

  assign out_v = v[NS-1];

endmodule

// ===== hw/rtl/battery_adc_to_charge.sv =====
// battery adc sample to millivolts and charge percent, top level
// an accepted sample reaches the output through the pipeline stages and then the output register
// throughput: one sample per cycle while the skid register is empty; 25 pipeline stages, 16 of them the divider
// a skid register behind the output keeps input flowing for one stalled beat
// reset (synchronous, active high) clears all valid bits and loads the
// register defaults: full scale 4095, reference 3300 mV, divider 100k / 22k
`include "assert_macros.svh"

module battery_adc_to_charge (
  input  logic            clk,
  input  logic            rst,
  adc_sample_if.sink      sample,
  charge_result_if.source result,
  cfg_write_if.sink       cfg
);
  import bcharge_pkg::*;

  cfg_t    cfg_q;
  logic    en;
  logic    sc_v;
  logic [MV_W-1:0] sc_mv;
  logic    p_v;
  result_t p;
  result_t o, s;
  logic    o_v, s_v;

  // configuration registers, write always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.full_scale   <= FULL_SCALE_RST;
      cfg_q.reference_mv <= REFERENCE_MV_RST;
      cfg_q.divider_high <= DIVIDER_HIGH_RST;
      cfg_q.divider_low  <= DIVIDER_LOW_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_FULL_SCALE:   cfg_q.full_scale   <= cfg.data[SAMPLE_W-1:0];
        REG_REFERENCE_MV: cfg_q.reference_mv <= cfg.data[REF_W-1:0];
        REG_DIVIDER_HIGH: cfg_q.divider_high <= cfg.data[KOHM_W-1:0];
        REG_DIVIDER_LOW:  cfg_q.divider_low  <= cfg.data[KOHM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the skid slot is free
  assign en           = !s_v;
  assign sample.ready = en;

  bcharge_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (sample.valid),
    .code  (sample.adc_sample),
    .cfg   (cfg_q),
    .out_v (sc_v),
    .mv    (sc_mv)
  );

  bcharge_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (sc_v),
    .mv     (sc_mv),
    .out_v  (p_v),
    .mv_out (p.mv),
    .pct    (p.pct)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      s_v <= 1'b0;
    end else if (result.ready || !o_v) begin
      if (s_v) begin
        o   <= s;
        o_v <= 1'b1;
        s_v <= 1'b0;
      end else begin
        o   <= p;
        o_v <= p_v;
      end
    end else if (p_v && !s_v) begin
      s   <= p;
      s_v <= 1'b1;
    end
  end

  assign result.valid              = o_v;
  assign result.battery_millivolts = o.mv;
  assign result.charge_percent     = o.pct;

  // checks
  `ASSERT_IMPLY(a_skid_behind_out, clk, rst, s_v, o_v, "skid beat without output beat")
  `ASSERT_IMPLY(a_skid_fill, clk, rst, $rose(s_v), $past(o_v && !result.ready), "skid filled without stall")
  `ASSERT_NEXT(a_skid_drain, clk, rst, s_v && result.ready, o_v && !s_v, "skid beat not moved to output")
  `ASSERT_IMPLY(a_full_clamp, clk, rst, o_v && (o.mv >= MV_CEIL), o.pct == PCT_FULL, "charge not full above curve")

endmodule

// ===== sim/battery_charge_checker.sv =====
// checker for the battery adc converter: predicts millivolts and charge, compares each beat
`timescale 1ns / 100ps

module battery_charge_checker (
  input  logic     clk,
  input  logic     rst,
  adc_sample_if    sample,
  charge_result_if result,
  cfg_write_if     cfg,
  output int       fails,
  output int       backlog,
  output int       checked
);
  import bcharge_pkg::*;

  // five-point 3s lipo discharge curve
  localparam int unsigned KNEE_MV  [5] = '{10500, 11100, 11550, 12000, 12600};
  localparam int unsigned KNEE_PCT [5] = '{0, 15, 50, 80, 100};
  localparam int unsigned MV_SAT = 65535;

  cfg_t    settings;
  result_t pending_charge [$];
  result_t want;
  int      err_count;
  int      ok_count;

  // rounded interpolation over the curve, clamped at both ends
  function automatic logic [PCT_W-1:0] curve_percent(input int unsigned mv);
    int unsigned span;
    int unsigned rise;
    int unsigned off;
    if (mv <= KNEE_MV[0]) return PCT_W'(KNEE_PCT[0]);
    if (mv >= KNEE_MV[4]) return PCT_W'(KNEE_PCT[4]);
    for (int k = 1; k < 5; k++) begin
      if (mv <= KNEE_MV[k]) begin
        span = KNEE_MV[k] - KNEE_MV[k-1];
        rise = KNEE_PCT[k] - KNEE_PCT[k-1];
        off  = mv - KNEE_MV[k-1];
        return PCT_W'(KNEE_PCT[k-1] + (off * rise + span / 2) / span);
      end
    end
    return PCT_W'(KNEE_PCT[4]);
  endfunction

  // clamp, scale through the divider with rounding, saturate, then map to percent
  function automatic result_t expected_charge(input cfg_t c, input logic [SAMPLE_W-1:0] code);
    longint unsigned clamped;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    result_t r;
    clamped = (code > c.full_scale) ? longint'(c.full_scale) : longint'(code);
    num = clamped * longint'(c.reference_mv) * (longint'(c.divider_high) + longint'(c.divider_low));
    den = longint'(c.full_scale) * longint'(c.divider_low);
    if (den == 0) begin
      q = MV_SAT;
    end else begin
      q = (num + den / 2) / den;
      if (q > MV_SAT) q = MV_SAT;
    end
    r.mv  = MV_W'(q);
    r.pct = curve_percent(int'(q));
    return r;
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      settings.full_scale   = FULL_SCALE_RST;
      settings.reference_mv = REFERENCE_MV_RST;
      settings.divider_high = DIVIDER_HIGH_RST;
      settings.divider_low  = DIVIDER_LOW_RST;
      pending_charge.delete();
      err_count = 0;
      ok_count  = 0;
    end else begin
      // register writes, masked to register width
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_FULL_SCALE:   settings.full_scale   = cfg.data[SAMPLE_W-1:0];
          REG_REFERENCE_MV: settings.reference_mv = cfg.data[REF_W-1:0];
          REG_DIVIDER_HIGH: settings.divider_high = cfg.data[KOHM_W-1:0];
          REG_DIVIDER_LOW:  settings.divider_low  = cfg.data[KOHM_W-1:0];
          default: ;
        endcase
      end
      // accepted sample beat
      if (sample.valid && sample.ready)
        pending_charge.push_back(expected_charge(settings, sample.adc_sample));
      // accepted result beat
      if (result.valid && result.ready) begin
        if (pending_charge.size() == 0) begin
          err_count++;
          $display("%0t unexpected result: expected none, actual mv %0d pct %0d", $time,
                   result.battery_millivolts, result.charge_percent);
        end else begin
          want = pending_charge.pop_front();
          ok_count++;
          if (result.battery_millivolts !== want.mv) begin
            err_count++;
            $display("%0t battery_millivolts mismatch: expected %0d actual %0d", $time,
                     want.mv, result.battery_millivolts);
          end
          if (result.charge_percent !== want.pct) begin
            err_count++;
            $display("%0t charge_percent mismatch: expected %0d actual %0d (mv %0d)", $time,
                     want.pct, result.charge_percent, want.mv);
          end
        end
      end
    end
    fails   <= err_count;
    backlog <= pending_charge.size();
    checked <= ok_count;
  end

endmodule

// ===== sim/battery_adc_to_charge_test.sv =====
// testbench top for the battery adc converter: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module battery_adc_to_charge_test;
  import bcharge_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 30;

  logic clk;
  logic rst;
  int   fails;
  int   backlog;
  int   checked;
  int   cycles = 0;
  int   samples_sent;
  int   reg_writes;
  int   settings_used;
  int   send_gap;
  int   recv_gap;

  // register values currently loaded, masked
  int unsigned cur_fs;
  int unsigned cur_ref;
  int unsigned cur_hi;
  int unsigned cur_lo;

  adc_sample_if    sample_ch ();
  charge_result_if result_ch ();
  cfg_write_if     cfg_ch ();

  battery_adc_to_charge u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  battery_charge_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .backlog (backlog),
    .checked (checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, backlog);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_gap);
    end
  end

  // one sample beat, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] code);
    while ($urandom_range(99) < send_gap) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.adc_sample <= code;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  // hold off input until every expected result has come back
  task automatic wait_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // load all four registers; upper data bits are dropped by the block
  task automatic load_settings(input logic [15:0] fs, input logic [15:0] refmv,
                               input logic [15:0] hi, input logic [15:0] lo);
    write_reg(REG_FULL_SCALE, fs);
    write_reg(REG_REFERENCE_MV, refmv);
    write_reg(REG_DIVIDER_HIGH, hi);
    write_reg(REG_DIVIDER_LOW, lo);
    cur_fs  = 32'(fs);
    cur_ref = 32'(refmv & 16'h1FFF);
    cur_hi  = 32'(hi & 16'h03FF);
    cur_lo  = 32'(lo & 16'h03FF);
    settings_used++;
  endtask

  // mostly codes that land on the charge curve, the rest spread wide
  function automatic logic [SAMPLE_W-1:0] pick_code();
    int unsigned     sel;
    int              near;
    longint unsigned gain_den;
    longint unsigned target;
    sel      = $urandom_range(99);
    gain_den = longint'(cur_ref) * (longint'(cur_hi) + longint'(cur_lo));
    if (sel < 60 && gain_den != 0 && cur_fs != 0 && cur_lo != 0) begin
      target = longint'($urandom_range(13200, 9800)) * cur_fs * cur_lo / gain_den;
      return (target > 65535) ? 16'hFFFF : 16'(target);
    end
    if (sel < 80) return 16'($urandom_range(65535));
    if (sel < 90) begin
      near = int'(cur_fs) + int'($urandom_range(4)) - 2;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      return 16'(near);
    end
    case ($urandom_range(2))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'(cur_fs);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [SAMPLE_W-1:0] edge_codes [16];
    int                  batch [8];
    rst                  <= 1'b1;
    sample_ch.valid      <= 1'b0;
    sample_ch.adc_sample <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_FULL_SCALE;
    cfg_ch.data          <= '0;
    send_gap      = 22;
    recv_gap      = 57;
    samples_sent  = 0;
    reg_writes    = 0;
    settings_used = 1;
    cur_fs  = 4095;
    cur_ref = 3300;
    cur_hi  = 100;
    cur_lo  = 22;
    edge_codes = '{10499, 10500, 10501, 10800, 11100, 11101, 11550, 11551,
                   12000, 12001, 12599, 12600, 12601, 20000, 20001, 65535};
    batch      = '{80, 80, 60, 60, 30, 30, 130, 130};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero, full scale and clamping
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'd4094);
    send_sample(16'd4095);
    send_sample(16'd4096);
    send_sample(16'hFFFF);
    wait_results();

    // unity gain (20000 full scale, 5000 mv, 3:1 divider): code equals millivolts,
    // so each breakpoint and both clamps of the curve are hit exactly
    load_settings(16'd20000, 16'd5000, 16'd3, 16'd1);
    foreach (edge_codes[k]) send_sample(edge_codes[k]);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      wait_results();
      case (ph)
        0: ;
        1: load_settings(16'd4095, 16'd3300, 16'd100, 16'd22);
        // largest gain, reference and divider given with all data bits set
        2: load_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
        // smallest gain
        3: load_settings(16'hFFFF, 16'd1, 16'd0, 16'd1000);
        // zero full scale
        4: load_settings(16'd0, 16'($urandom_range(8191)), 16'($urandom_range(1023)),
                         16'($urandom_range(1023, 1)));
        // zero lower divider
        5: load_settings(16'($urandom_range(65535, 1)), 16'd3300, 16'd100, 16'd0);
        default: load_settings(16'($urandom_range(65535, 1)),
                               16'(($urandom_range(7) << 13) | $urandom_range(8191, 1)),
                               16'(($urandom_range(63) << 10) | $urandom_range(1000)),
                               16'(($urandom_range(63) << 10) | $urandom_range(1000, 1)));
      endcase
      if (ph < 3) begin
        send_gap = 22;
        recv_gap = 57;
      end else if (ph < 6) begin
        send_gap = 57;
        recv_gap = 22;
      end else begin
        send_gap = 0;
        recv_gap = 0;
      end
      for (int i = 0; i < batch[ph]; i++) begin
        if (ph == 6 && i == 50) wait_results();
        send_sample(pick_code());
      end
    end

    // drain and verdict
    wait_results();
    $display("covered %0d samples under %0d register settings (%0d register writes)",
             samples_sent, settings_used, reg_writes);
    $display("%0d results checked, %0d mismatches", checked, fails);
    if (fails == 0 && backlog == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
